@@ hw/rtl/imhq_pkg.sv @@
// ----------------------------------------------------------------------------
// imhq_pkg: shared types and codes for the indexed min-heap queue
// Operation kinds, status codes, key limits and sequencer states.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam logic signed [63:0] KEY_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELMIN = 2'd1,
    KIND_CHANGE = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_BADHNDL  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_OLD_RD,
    S_OLD_CMP,
    S_CHG_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMPR,
    S_DN_PICK,
    S_POP,
    S_POP_LAST,
    S_FIN,
    S_MIN_RD,
    S_MIN_WT,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/imhq_if.sv @@
// ----------------------------------------------------------------------------
// imhq_in_if / imhq_out_if: valid-ready channels of the heap queue
// Command beat in, result beat out.
// ----------------------------------------------------------------------------
interface imhq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [63:0] key_in;
  logic [9:0]  handle_in;
  modport source (output valid, kind, key_in, handle_in, input ready);
  modport sink   (input valid, kind, key_in, handle_in, output ready);
endinterface

interface imhq_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  handle_out;
  logic signed [63:0] key_out;
  logic [1:0]  status;
  logic signed [63:0] min_key;
  logic        min_valid;
  logic [10:0] entry_total;
  modport source (output valid, handle_out, key_out, status, min_key, min_valid,
                  entry_total, input ready);
  modport sink   (input valid, handle_out, key_out, status, min_key, min_valid,
                  entry_total, output ready);
endinterface

@@ hw/rtl/indexed_min_heap_queue.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap_queue: indexed binary min-heap priority queue
// Heap slots (key, handle) and a handle-to-position map in memories, one
// shared key comparator and a sequencer that walks sift up / sift down.
// ----------------------------------------------------------------------------
// channel  dir  beat
// cmd      in   kind, key_in, handle_in
// rsp      out  handle_out, key_out, status, min_key, min_valid, entry_total
//
// After reset a clearing pass loads handle i and position i into every slot
// (and a zero key); no command is taken meanwhile. A command is taken only
// in idle, so no new command is accepted until the last one has finished.
// The result waits in the output register; while an earlier result is still
// stalled there, the sequencer holds in its done state.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic clk,
  input  logic rst,
  imhq_in_if.sink    cmd,
  imhq_out_if.source rsp
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = AW + 1;

  logic signed [63:0] keys  [CAPACITY];
  logic [AW-1:0]      hdls  [CAPACITY];
  logic [AW-1:0]      hpos  [CAPACITY];

  imhq_pkg::state_t state, state_next;

  logic [CW-1:0]      count;
  logic [AW-1:0]      clr;
  imhq_pkg::kind_t    kind;
  logic signed [63:0] key_r;
  logic [9:0]         hin;
  logic               force_up;
  logic               left_ties;

  logic [AW-1:0]      cur;
  logic signed [63:0] kc, ko, kl, kr, pk;
  logic [AW-1:0]      hc, hl, hr, ph;
  logic               lv, rv;

  logic signed [63:0] rd_key;
  logic [AW-1:0]      rd_hdl, rd_pos;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      paddr;

  logic               wr_en, pw_en;
  logic [AW-1:0]      wr_a, wr_h, pw_a, pw_d;
  logic signed [63:0] wr_k;

  logic [9:0]         hout;
  logic signed [63:0] kout;
  imhq_pkg::status_t  st;
  logic signed [63:0] mink;

  logic signed [63:0] ca, cb;
  logic               lt;

  logic [CW-1:0]      lw, rw, cnt_dec;
  logic [AW-1:0]      par;
  logic               l_in, r_in;
  logic               full, empty, bad;
  logic               take, take_r;
  logic               done_go;

  assign lt      = ca < cb;
  assign lw      = {cur, 1'b1};
  assign rw      = lw + CW'(1);
  assign par     = (cur - AW'(1)) >> 1;
  assign l_in    = lw < count;
  assign r_in    = rw < count;
  assign cnt_dec = count - CW'(1);
  assign full    = count >= CW'(CAPACITY);
  assign empty   = count == '0;
  assign bad     = (32'(hin) >= CAPACITY) || (CW'(rd_pos) >= count);
  assign take    = lv || rv;
  assign take_r  = rv && (!lv || (left_ties ? lt : !lt));
  assign done_go = !rsp.valid || rsp.ready;

  assign cmd.ready = (state == imhq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    rd_key <= keys[raddr];
    rd_hdl <= hdls[raddr];
    rd_pos <= hpos[paddr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      keys[wr_a] <= wr_k;
      hdls[wr_a] <= wr_h;
    end
    if (pw_en) hpos[pw_a] <= pw_d;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      imhq_pkg::S_CLEAR: if (clr == AW'(CAPACITY - 1)) state_next = imhq_pkg::S_IDLE;
      imhq_pkg::S_IDLE:  if (cmd.valid) state_next = imhq_pkg::S_LOOK;
      imhq_pkg::S_LOOK:  state_next = imhq_pkg::S_DECIDE;
      imhq_pkg::S_DECIDE: begin
        priority if (kind == imhq_pkg::KIND_INSERT)
          state_next = full ? imhq_pkg::S_MIN_RD : imhq_pkg::S_UP_RD;
        else if (kind == imhq_pkg::KIND_DELMIN)
          state_next = empty ? imhq_pkg::S_MIN_RD : imhq_pkg::S_POP;
        else
          state_next = bad ? imhq_pkg::S_MIN_RD : imhq_pkg::S_OLD_RD;
      end
      imhq_pkg::S_OLD_RD: state_next = imhq_pkg::S_OLD_CMP;
      imhq_pkg::S_OLD_CMP: begin
        if (kind == imhq_pkg::KIND_REMOVE || lt) state_next = imhq_pkg::S_UP_RD;
        else state_next = imhq_pkg::S_CHG_CMP;
      end
      imhq_pkg::S_CHG_CMP: state_next = lt ? imhq_pkg::S_DN_RDL : imhq_pkg::S_FIN;
      imhq_pkg::S_UP_RD: begin
        if (cur != '0) state_next = imhq_pkg::S_UP_CMP;
        else state_next = force_up ? imhq_pkg::S_POP : imhq_pkg::S_FIN;
      end
      imhq_pkg::S_UP_CMP:
        state_next = (force_up || lt) ? imhq_pkg::S_UP_RD : imhq_pkg::S_FIN;
      imhq_pkg::S_DN_RDL: state_next = l_in ? imhq_pkg::S_DN_RDR : imhq_pkg::S_FIN;
      imhq_pkg::S_DN_RDR: state_next = imhq_pkg::S_DN_CMPR;
      imhq_pkg::S_DN_CMPR: state_next = imhq_pkg::S_DN_PICK;
      imhq_pkg::S_DN_PICK: state_next = take ? imhq_pkg::S_DN_RDL : imhq_pkg::S_FIN;
      imhq_pkg::S_POP:
        state_next = (cnt_dec == '0) ? imhq_pkg::S_MIN_RD : imhq_pkg::S_POP_LAST;
      imhq_pkg::S_POP_LAST: state_next = imhq_pkg::S_DN_RDL;
      imhq_pkg::S_FIN:    state_next = imhq_pkg::S_MIN_RD;
      imhq_pkg::S_MIN_RD: state_next = imhq_pkg::S_MIN_WT;
      imhq_pkg::S_MIN_WT: state_next = imhq_pkg::S_DONE;
      imhq_pkg::S_DONE:   if (done_go) state_next = imhq_pkg::S_IDLE;
      default:            state_next = imhq_pkg::S_IDLE;
    endcase
  end

  // shared comparator operands
  always_comb begin
    ca = kc;
    cb = ko;
    unique case (state)
      imhq_pkg::S_OLD_CMP: begin ca = key_r; cb = rd_key; end
      imhq_pkg::S_CHG_CMP: begin ca = ko; cb = kc; end
      imhq_pkg::S_UP_CMP:  begin ca = kc; cb = rd_key; end
      imhq_pkg::S_DN_RDR:  begin ca = rd_key; cb = kc; end
      imhq_pkg::S_DN_CMPR: begin ca = rd_key; cb = kc; end
      imhq_pkg::S_DN_PICK: begin
        ca = left_ties ? kr : kl;
        cb = left_ties ? kl : kr;
      end
      default: ;
    endcase
  end

  // memory ports
  always_comb begin
    raddr = cur;
    paddr = AW'(hin);
    wr_en = 1'b0;
    pw_en = 1'b0;
    wr_a  = cur;
    wr_k  = kc;
    wr_h  = hc;
    pw_a  = hc;
    pw_d  = cur;
    unique case (state)
      imhq_pkg::S_CLEAR: begin
        wr_en = 1'b1; wr_a = clr; wr_k = '0; wr_h = clr;
        pw_en = 1'b1; pw_a = clr; pw_d = clr;
      end
      imhq_pkg::S_LOOK: raddr = (kind == imhq_pkg::KIND_INSERT) ? AW'(count) : '0;
      imhq_pkg::S_UP_RD: raddr = par;
      imhq_pkg::S_UP_CMP: begin
        if (force_up || lt) begin
          wr_en = 1'b1; wr_k = rd_key; wr_h = rd_hdl;
          pw_en = 1'b1; pw_a = rd_hdl;
        end
      end
      imhq_pkg::S_DN_RDL: raddr = lw[AW-1:0];
      imhq_pkg::S_DN_RDR: raddr = rw[AW-1:0];
      imhq_pkg::S_DN_PICK: begin
        if (take) begin
          wr_en = 1'b1; wr_k = take_r ? kr : kl; wr_h = take_r ? hr : hl;
          pw_en = 1'b1; pw_a = take_r ? hr : hl;
        end
      end
      imhq_pkg::S_POP: begin
        raddr = AW'(cnt_dec);
        if (cnt_dec == '0) begin
          wr_en = 1'b1; wr_a = '0; wr_k = pk; wr_h = ph;
          pw_en = 1'b1; pw_a = ph; pw_d = '0;
        end
      end
      imhq_pkg::S_POP_LAST: begin
        wr_en = 1'b1; wr_a = AW'(count); wr_k = pk; wr_h = ph;
        pw_en = 1'b1; pw_a = ph; pw_d = AW'(count);
      end
      imhq_pkg::S_FIN: begin
        wr_en = 1'b1;
        pw_en = 1'b1;
      end
      imhq_pkg::S_MIN_RD: raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= imhq_pkg::S_CLEAR;
      clr       <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == imhq_pkg::S_DONE && done_go) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        imhq_pkg::S_CLEAR: clr <= clr + AW'(1);
        imhq_pkg::S_IDLE: if (cmd.valid) begin
          kind <= imhq_pkg::kind_t'(cmd.kind); key_r <= cmd.key_in;
          hin <= cmd.handle_in;
          hout <= '0; kout <= '0; st <= imhq_pkg::ST_OK;
        end
        imhq_pkg::S_DECIDE: begin
          priority if (kind == imhq_pkg::KIND_INSERT) begin
            if (full) st <= imhq_pkg::ST_FULL;
            else begin
              cur <= AW'(count); kc <= key_r; hc <= rd_hdl;
              hout <= 10'(rd_hdl); kout <= key_r;
              count <= count + CW'(1);
              force_up <= 1'b0;
            end
          end else if (kind == imhq_pkg::KIND_DELMIN) begin
            if (empty) st <= imhq_pkg::ST_EMPTY;
            else begin
              kout <= rd_key; hout <= 10'(rd_hdl); pk <= rd_key; ph <= rd_hdl;
            end
          end else begin
            if (bad) st <= imhq_pkg::ST_BADHNDL;
            else begin
              cur <= rd_pos; hc <= AW'(hin); kc <= key_r; hout <= hin;
            end
          end
        end
        imhq_pkg::S_OLD_CMP: begin
          ko <= rd_key;
          if (kind == imhq_pkg::KIND_REMOVE) begin
            kout <= rd_key; kc <= imhq_pkg::KEY_MIN; force_up <= 1'b1;
          end else begin
            kout <= key_r; force_up <= 1'b0;
          end
        end
        imhq_pkg::S_CHG_CMP: left_ties <= 1'b0;
        imhq_pkg::S_UP_RD: if (cur == '0 && force_up) begin
          pk <= kc; ph <= hc;
        end
        imhq_pkg::S_UP_CMP: if (force_up || lt) cur <= par;
        imhq_pkg::S_DN_RDR: begin
          kl <= rd_key; hl <= rd_hdl; lv <= lt;
        end
        imhq_pkg::S_DN_CMPR: begin
          kr <= rd_key; hr <= rd_hdl; rv <= r_in && lt;
        end
        imhq_pkg::S_DN_PICK: if (take) cur <= take_r ? rw[AW-1:0] : lw[AW-1:0];
        imhq_pkg::S_POP: count <= cnt_dec;
        imhq_pkg::S_POP_LAST: begin
          kc <= rd_key; hc <= rd_hdl; cur <= '0; left_ties <= 1'b1;
        end
        imhq_pkg::S_MIN_WT: mink <= (count != '0) ? rd_key : '0;
        imhq_pkg::S_DONE: if (done_go) begin
          rsp.handle_out  <= hout;
          rsp.key_out     <= kout;
          rsp.status      <= st;
          rsp.min_key     <= mink;
          rsp.min_valid   <= (count != '0);
          rsp.entry_total <= 11'(count);
        end
        default: ;
      endcase
    end
  end

endmodule

@@ verif/tb_indexed_min_heap_queue.sv @@
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_queue: self-checking bench for the indexed heap queue
// Drives command beats with bursty gaps, stalls the result side on its own
// pattern, predicts each result with a local heap and compares every field.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_queue;

  localparam int Cap = 1024;

  typedef struct packed {
    logic [9:0]         handle_out;
    logic signed [63:0] key_out;
    imhq_pkg::status_t  status;
    logic signed [63:0] min_key;
    logic               min_valid;
    logic [10:0]        entry_total;
  } heap_rsp_t;

  logic clk;
  logic rst;

  imhq_in_if  cmd ();
  imhq_out_if rsp ();

  indexed_min_heap_queue #(.CAPACITY(Cap)) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd.sink),
    .rsp(rsp.source)
  );

  logic signed [63:0] hp_key [Cap];
  logic [9:0]         hp_hnd [Cap];
  logic [9:0]         hnd_pos [Cap];
  int unsigned        live;

  heap_rsp_t rsp_pending[$];
  int        errors;
  bit        hold_off;
  int        burst_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb_indexed_min_heap_queue: errors");
    $finish;
  end

  function automatic void slot_swap(int a, int b);
    logic signed [63:0] k;
    logic [9:0]         h;
    k = hp_key[a];
    h = hp_hnd[a];
    hp_key[a] = hp_key[b];
    hp_hnd[a] = hp_hnd[b];
    hp_key[b] = k;
    hp_hnd[b] = h;
    hnd_pos[hp_hnd[a]] = 10'(a);
    hnd_pos[hp_hnd[b]] = 10'(b);
  endfunction

  function automatic void bubble_up(int i, bit forced);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!forced && !(hp_key[i] < hp_key[p])) break;
      slot_swap(i, p);
      i = p;
    end
  endfunction

  function automatic void sink_left(int i);
    int l, r, s;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      s = i;
      if (l < live && hp_key[l] < hp_key[i]) s = l;
      if (r < live && hp_key[r] < hp_key[s]) s = r;
      if (s == i) break;
      slot_swap(i, s);
      i = s;
    end
  endfunction

  function automatic void sink_right(int i);
    int  l, r, c;
    bit  lv, rv;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      lv = l < live && hp_key[l] < hp_key[i];
      rv = r < live && hp_key[r] < hp_key[i];
      if (!lv && !rv) break;
      if (!rv || (lv && hp_key[l] < hp_key[r])) c = l;
      else c = r;
      slot_swap(i, c);
      i = c;
    end
  endfunction

  function automatic int take_root();
    live--;
    if (live == 0) return 0;
    slot_swap(0, int'(live));
    sink_left(0);
    return int'(live);
  endfunction

  function automatic heap_rsp_t heap_apply(imhq_pkg::kind_t kind,
                                           logic signed [63:0] key, logic [9:0] h);
    heap_rsp_t          r;
    int                 i;
    logic signed [63:0] old;
    r = '0;
    r.status = imhq_pkg::ST_OK;
    if (kind == imhq_pkg::KIND_INSERT) begin
      if (live >= Cap) begin
        r.status = imhq_pkg::ST_FULL;
      end else begin
        i = int'(live);
        hp_key[i] = key;
        r.handle_out = hp_hnd[i];
        r.key_out = key;
        live++;
        bubble_up(i, 1'b0);
      end
    end else if (kind == imhq_pkg::KIND_DELMIN) begin
      if (live == 0) begin
        r.status = imhq_pkg::ST_EMPTY;
      end else begin
        i = take_root();
        r.handle_out = hp_hnd[i];
        r.key_out = hp_key[i];
      end
    end else if (hnd_pos[h] >= live) begin
      r.status = imhq_pkg::ST_BADHNDL;
    end else if (kind == imhq_pkg::KIND_CHANGE) begin
      i = hnd_pos[h];
      old = hp_key[i];
      hp_key[i] = key;
      if (key < old) bubble_up(i, 1'b0);
      else if (old < key) sink_right(i);
      r.handle_out = h;
      r.key_out = key;
    end else begin
      i = hnd_pos[h];
      r.key_out = hp_key[i];
      hp_key[i] = imhq_pkg::KEY_MIN;
      bubble_up(i, 1'b1);
      void'(take_root());
      r.handle_out = h;
    end
    r.min_valid = live > 0;
    r.min_key = live > 0 ? hp_key[0] : '0;
    r.entry_total = live[10:0];
    return r;
  endfunction

  task automatic send_beat(imhq_pkg::kind_t kind, logic signed [63:0] key,
                           logic [9:0] h);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    cmd.valid <= 1'b1;
    cmd.kind <= kind;
    cmd.key_in <= key;
    cmd.handle_in <= h;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    rsp_pending.push_back(heap_apply(kind, key, h));
  endtask

  task automatic pause_beats();
    cmd.valid <= 1'b0;
    @(posedge clk);
    while (rsp_pending.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic signed [63:0] rand_key(bit narrow);
    logic signed [63:0] k;
    k = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: k = imhq_pkg::KEY_MIN;
      1: k = 64'sh7fff_ffff_ffff_ffff;
      2: k = $signed(64'($urandom_range(0, 15))) - 8;
      default: if (narrow) k = $signed(64'($urandom_range(0, 63))) - 32;
    endcase
    return k;
  endfunction

  function automatic logic [9:0] pick_handle();
    if (live > 0 && $urandom_range(0, 9) != 0)
      return hp_hnd[$urandom_range(0, live - 1)];
    return 10'($urandom);
  endfunction

  always @(posedge clk) begin
    heap_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (rsp_pending.size() == 0) begin
        $display("%0t: unexpected result beat handle=%0d", $time, rsp.handle_out);
        errors++;
      end else begin
        want = rsp_pending.pop_front();
        if (rsp.handle_out !== want.handle_out) begin
          $display("%0t: handle_out exp %0d got %0d", $time, want.handle_out,
                   rsp.handle_out);
          errors++;
        end
        if (rsp.key_out !== want.key_out) begin
          $display("%0t: key_out exp %0d got %0d", $time, want.key_out, rsp.key_out);
          errors++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, rsp.status);
          errors++;
        end
        if (rsp.min_key !== want.min_key) begin
          $display("%0t: min_key exp %0d got %0d", $time, want.min_key, rsp.min_key);
          errors++;
        end
        if (rsp.min_valid !== want.min_valid) begin
          $display("%0t: min_valid exp %0d got %0d", $time, want.min_valid,
                   rsp.min_valid);
          errors++;
        end
        if (rsp.entry_total !== want.entry_total) begin
          $display("%0t: entry_total exp %0d got %0d", $time, want.entry_total,
                   rsp.entry_total);
          errors++;
        end
      end
    end
  end

  // stall on a pattern: long hold-off when requested, else random duty
  always @(posedge clk) begin
    if (rst || hold_off) rsp.ready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) rsp.ready <= ($urandom_range(0, 3) == 0);
    else rsp.ready <= 1'b1;
  end

  task automatic test_directed();
    send_beat(imhq_pkg::KIND_DELMIN, '0, '0);
    send_beat(imhq_pkg::KIND_CHANGE, 64'sd5, 10'd0);
    send_beat(imhq_pkg::KIND_REMOVE, '0, 10'd1023);
    send_beat(imhq_pkg::KIND_INSERT, 64'sh7fff_ffff_ffff_ffff, '0);
    send_beat(imhq_pkg::KIND_INSERT, imhq_pkg::KEY_MIN, '0);
    send_beat(imhq_pkg::KIND_INSERT, 64'sd0, '0);
    send_beat(imhq_pkg::KIND_INSERT, 64'sd0, '0);
    send_beat(imhq_pkg::KIND_INSERT, -64'sd1, '0);
    send_beat(imhq_pkg::KIND_INSERT, 64'sd7, '0);
    send_beat(imhq_pkg::KIND_CHANGE, 64'sd9, 10'd1);
    send_beat(imhq_pkg::KIND_CHANGE, 64'sd3, 10'd1);
    send_beat(imhq_pkg::KIND_CHANGE, 64'sd3, 10'd1);
    send_beat(imhq_pkg::KIND_CHANGE, 64'sd9, 10'd3);
    send_beat(imhq_pkg::KIND_REMOVE, '0, 10'd4);
    send_beat(imhq_pkg::KIND_REMOVE, '0, 10'd1023);
    send_beat(imhq_pkg::KIND_DELMIN, '0, '0);
    send_beat(imhq_pkg::KIND_DELMIN, '0, '0);
    send_beat(imhq_pkg::KIND_REMOVE, '0, 10'd0);
    send_beat(imhq_pkg::KIND_DELMIN, '0, '0);
    send_beat(imhq_pkg::KIND_DELMIN, '0, '0);
    send_beat(imhq_pkg::KIND_DELMIN, '0, '0);
    pause_beats();
  endtask

  task automatic test_fill_stall();
    int n;
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (n = 0; n < 30; n++) send_beat(imhq_pkg::KIND_INSERT, rand_key(1'b1), '0);
    join
    pause_beats();
  endtask

  task automatic test_full();
    while (live < Cap) send_beat(imhq_pkg::KIND_INSERT, rand_key(1'b1), '0);
    send_beat(imhq_pkg::KIND_INSERT, 64'sd1, '0);
    send_beat(imhq_pkg::KIND_CHANGE, imhq_pkg::KEY_MIN, 10'd1023);
    send_beat(imhq_pkg::KIND_REMOVE, '0, 10'd512);
    send_beat(imhq_pkg::KIND_INSERT, 64'sh7fff_ffff_ffff_ffff, '0);
    while (live > 950) begin
      if ($urandom_range(0, 1) == 0) send_beat(imhq_pkg::KIND_DELMIN, '0, '0);
      else send_beat(imhq_pkg::KIND_REMOVE, '0, pick_handle());
    end
    pause_beats();
  endtask

  task automatic test_random();
    int              n;
    int              r;
    imhq_pkg::kind_t k;
    bit              narrow;
    for (n = 0; n < 150; n++) begin
      r = $urandom_range(0, 99);
      narrow = $urandom_range(0, 1);
      if (live < 40 && r < 50) k = imhq_pkg::KIND_INSERT;
      else if (r < 35) k = imhq_pkg::KIND_INSERT;
      else if (r < 55) k = imhq_pkg::KIND_DELMIN;
      else if (r < 80) k = imhq_pkg::KIND_CHANGE;
      else k = imhq_pkg::KIND_REMOVE;
      send_beat(k, rand_key(narrow), pick_handle());
    end
    pause_beats();
  endtask

  initial begin
    errors = 0;
    hold_off = 1'b0;
    burst_left = 0;
    live = 0;
    for (int i = 0; i < Cap; i++) begin
      hp_key[i] = '0;
      hp_hnd[i] = 10'(i);
      hnd_pos[i] = 10'(i);
    end
    rst = 1'b1;
    cmd.valid = 1'b0;
    cmd.kind = imhq_pkg::KIND_INSERT;
    cmd.key_in = '0;
    cmd.handle_in = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_stall();
    test_random();
    test_full();
    repeat (200) @(posedge clk);
    if (errors == 0 && rsp_pending.size() == 0)
      $display("tb_indexed_min_heap_queue: clean");
    else
      $display("tb_indexed_min_heap_queue: errors");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/imhq_pkg.sv
hw/rtl/imhq_if.sv
hw/rtl/indexed_min_heap_queue.sv
verif/tb_indexed_min_heap_queue.sv
